// ===== hdl/utf8seg_pkg.sv =====
package utf8seg_pkg;

  // Depth of the request queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Most results one input byte can cause.
  localparam int MAX_RESULTS = 4;

  // Lead byte classification masks and patterns.
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] MASK_2      = 8'hE0;
  localparam logic [7:0] LEAD_2      = 8'hC0;
  localparam logic [7:0] MASK_3      = 8'hF0;
  localparam logic [7:0] LEAD_3      = 8'hE0;
  localparam logic [7:0] MASK_4      = 8'hF8;
  localparam logic [7:0] LEAD_4      = 8'hF0;
  localparam logic [7:0] MASK_CONT   = 8'hC0;
  localparam logic [7:0] CONT_BITS   = 8'h80;

  // Sequence lengths; LEN_SINGLE means the byte goes out alone.
  localparam logic [2:0] LEN_SINGLE = 3'd0;
  localparam logic [2:0] LEN_TWO    = 3'd2;
  localparam logic [2:0] LEN_THREE  = 3'd3;
  localparam logic [2:0] LEN_FOUR   = 3'd4;

  // One request: the results caused by one input byte.
  // Byte results come first, in order, then the end marker if there is one.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [2:0]                  byte_cnt;
    logic                        marker;
    logic                        chunk_done;
    logic [1:0]                  dropped;
  } job_t;

endpackage

// ===== hdl/utf8seg_front.sv =====
module utf8seg_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  output logic              job_valid,
  input  logic              job_ready,
  output utf8seg_pkg::job_t job_data
);

  logic [7:0] held_r [3];
  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic [2:0] exp_len_r, exp_len_nxt;

  logic [7:0] c;
  logic [2:0] lead_len;
  logic       is_open, is_cont;
  logic       flush, emit_c, hold_lead, store_cont;
  logic [1:0] new_cnt;
  logic [2:0] new_len;
  logic [2:0] byte_cnt;
  logic       marker;
  logic       accept;

  assign c         = in_tdata;
  assign is_open   = (held_cnt_r != 2'd0) && (exp_len_r != 3'd0);
  assign is_cont   = (c & utf8seg_pkg::MASK_CONT) == utf8seg_pkg::CONT_BITS;
  assign in_tready = job_ready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    if (c < utf8seg_pkg::ASCII_LIMIT) begin
      lead_len = utf8seg_pkg::LEN_SINGLE;
    end else if ((c & utf8seg_pkg::MASK_2) == utf8seg_pkg::LEAD_2) begin
      lead_len = utf8seg_pkg::LEN_TWO;
    end else if ((c & utf8seg_pkg::MASK_3) == utf8seg_pkg::LEAD_3) begin
      lead_len = utf8seg_pkg::LEN_THREE;
    end else if ((c & utf8seg_pkg::MASK_4) == utf8seg_pkg::LEAD_4) begin
      lead_len = utf8seg_pkg::LEN_FOUR;
    end else begin
      lead_len = utf8seg_pkg::LEN_SINGLE;
    end
  end

  always_comb begin
    flush      = 1'b0;
    emit_c     = 1'b0;
    hold_lead  = 1'b0;
    store_cont = 1'b0;
    if (!is_open) begin
      emit_c    = (lead_len == utf8seg_pkg::LEN_SINGLE);
      hold_lead = (lead_len != utf8seg_pkg::LEN_SINGLE);
    end else if (is_cont) begin
      if (({1'b0, held_cnt_r} + 3'd1) >= exp_len_r) begin
        flush  = 1'b1;
        emit_c = 1'b1;
      end else begin
        store_cont = 1'b1;
      end
    end else begin
      // A broken sequence goes out as it is; the byte then starts over.
      flush     = 1'b1;
      emit_c    = (lead_len == utf8seg_pkg::LEN_SINGLE);
      hold_lead = (lead_len != utf8seg_pkg::LEN_SINGLE);
    end
  end

  always_comb begin
    if (hold_lead) begin
      new_cnt = 2'd1;
      new_len = lead_len;
    end else if (store_cont) begin
      new_cnt = held_cnt_r + 2'd1;
      new_len = exp_len_r;
    end else begin
      new_cnt = 2'd0;
      new_len = 3'd0;
    end
  end

  assign byte_cnt = (flush ? {1'b0, held_cnt_r} : 3'd0) + {2'b00, emit_c};
  assign marker   = in_tlast && ((new_cnt != 2'd0) || (byte_cnt == 3'd0));

  // The new byte always lands right behind the flushed held bytes.
  always_comb begin
    job_data.bytes[0]   = (flush && held_cnt_r >= 2'd1) ? held_r[0] : c;
    job_data.bytes[1]   = (flush && held_cnt_r >= 2'd2) ? held_r[1] : c;
    job_data.bytes[2]   = (flush && held_cnt_r == 2'd3) ? held_r[2] : c;
    job_data.bytes[3]   = c;
    job_data.byte_cnt   = byte_cnt;
    job_data.marker     = marker;
    job_data.chunk_done = in_tlast;
    job_data.dropped    = marker ? new_cnt : 2'd0;
  end

  assign job_valid = accept && ((byte_cnt != 3'd0) || marker);

  always_comb begin
    held_cnt_nxt = held_cnt_r;
    exp_len_nxt  = exp_len_r;
    if (accept) begin
      held_cnt_nxt = in_tlast ? 2'd0 : new_cnt;
      exp_len_nxt  = in_tlast ? 3'd0 : new_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      exp_len_r  <= 3'd0;
    end else begin
      held_cnt_r <= held_cnt_nxt;
      exp_len_r  <= exp_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_lead) begin
      held_r[0] <= c;
    end else if (accept && store_cont) begin
      held_r[held_cnt_r] <= c;
    end
  end

`ifndef SYNTHESIS
  a_hold_fits: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r != 2'd0 |-> exp_len_r > {1'b0, held_cnt_r})
    else $error("held bytes reach or exceed the sequence length");

  a_chunk_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> held_cnt_r == 2'd0 && exp_len_r == 3'd0)
    else $error("hold not cleared after chunk end");
`endif

endmodule

// ===== hdl/utf8seg_queue.sv =====
module utf8seg_queue #(
  parameter int DEPTH = utf8seg_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  utf8seg_pkg::job_t wr_data,
  output logic              rd_valid,
  input  logic              rd_pop,
  output utf8seg_pkg::job_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  utf8seg_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push, pop;

  assign wr_ready = (cnt_r != FULL_CNT);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== hdl/utf8seg_back.sv =====
module utf8seg_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_pop,
  input  utf8seg_pkg::job_t job_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,
  output logic              out_tlast,
  output logic [1:0]        out_tuser
);

  utf8seg_pkg::job_t work_r;
  logic       work_valid_r, work_valid_nxt;
  logic [1:0] idx_r, idx_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_present_r;
  logic       out_last_r;
  logic       out_done_r;
  logic [1:0] out_dropped_r;

  logic [2:0] total;
  logic       is_last;
  logic       out_free;
  logic       emit;
  logic       present;

  assign total    = work_r.byte_cnt + {2'b00, work_r.marker};
  assign is_last  = ({1'b0, idx_r} + 3'd1) == total;
  assign out_free = !out_valid_r || out_tready;
  assign emit     = work_valid_r && out_free;
  assign job_pop  = job_valid && (!work_valid_r || (emit && is_last));
  assign present  = {1'b0, idx_r} < work_r.byte_cnt;

  always_comb begin
    work_valid_nxt = work_valid_r;
    idx_nxt        = idx_r;
    if (job_pop) begin
      work_valid_nxt = 1'b1;
      idx_nxt        = 2'd0;
    end else if (emit && is_last) begin
      work_valid_nxt = 1'b0;
      idx_nxt        = 2'd0;
    end else if (emit) begin
      idx_nxt = idx_r + 2'd1;
    end
    out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      idx_r        <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      work_r <= job_data;
    end
    if (emit) begin
      out_byte_r    <= present ? work_r.bytes[idx_r] : 8'h00;
      out_present_r <= present;
      out_last_r    <= is_last;
      out_done_r    <= is_last && work_r.chunk_done;
      out_dropped_r <= is_last ? work_r.dropped : 2'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_dropped_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_done_r, out_present_r};

`ifndef SYNTHESIS
  a_dropped_on_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dropped_r != 2'd0 |-> out_done_r && !out_present_r)
    else $error("dropped count outside a chunk end marker");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_last_r)
    else $error("chunk done on a result that is not the last of its byte");

  a_no_empty_request: assert property (@(posedge clk) disable iff (!rst_n)
    work_valid_r |-> total != 3'd0 && total <= 3'd4)
    else $error("request with no results or too many results");
`endif

endmodule

// ===== hdl/utf8_sequence_segmenter.sv =====
// UTF-8 sequence segmenter. Raw bytes of a chunk arrive one per request on the
// in_ channel, with in_tlast on the chunk's final byte, and only whole UTF-8
// sequences leave on the out_ channel, one byte per request. A lead byte opens
// a sequence of two, three or four bytes, which is held until its last
// continuation byte arrives and then released in order; ASCII and illegal lead
// bytes pass alone. When a continuation is missing, the held bytes go out as
// they are and the offending byte starts over as a lead byte. At chunk end any
// unfinished sequence is dropped: a bare end marker (byte_present low) carries
// chunk_done and the number of dropped bytes; otherwise the chunk's last byte
// carries chunk_done itself. out_tlast marks the last result caused by an
// input byte. Timing: the front accepts one byte every cycle while the request
// queue between front and back has room, and the back's output register sends
// one result per cycle while out_tready is high; a byte that is only held
// gives the back no work. An accepted byte's first result passes the queue,
// the back's work register and its output register.
module utf8_sequence_segmenter #(
  parameter int QUEUE_DEPTH = utf8seg_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input byte stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // chunk_end
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [9:8] dropped_count, [15:10] zero
  output logic        out_tlast,  // run_last
  output logic [1:0]  out_tuser   // [0] byte_present, [1] chunk_done
);

  // Requests built by the front, one per input byte that causes any result.
  utf8seg_pkg::job_t front_job;
  logic              front_valid;
  logic              queue_ready;

  // Requests handed from the queue to the back.
  utf8seg_pkg::job_t back_job;
  logic              back_valid;
  logic              back_pop;

  // The front tracks the open sequence and decides, per byte, which bytes
  // are released and whether an end marker follows.
  utf8seg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .job_valid (front_valid),
    .job_ready (queue_ready),
    .job_data  (front_job)
  );

  // The queue lets the front keep taking bytes while the back is still
  // sending out a multi-byte release.
  utf8seg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_ready (queue_ready),
    .wr_data  (front_job),
    .rd_valid (back_valid),
    .rd_pop   (back_pop),
    .rd_data  (back_job)
  );

  // The back steps through each request one result at a time into a
  // registered output stage.
  utf8seg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (back_valid),
    .job_pop    (back_pop),
    .job_data   (back_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== bench/utf8_sequence_segmenter_tb.sv =====
module utf8_sequence_segmenter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // This bound only catches a block that has hung.
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int RANDOM_ITEMS  = 98;   // least input requests in each pressure phase
  localparam int DRAIN_CYCLES  = 20;   // quiet time after the last result
  localparam int REPORT_LIMIT  = 10;

  // One result request as the block should send it.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       run_last;
    logic       chunk_done;
    logic [1:0] dropped;
  } seg_result_t;

  // One row of the directed table. Where typed is set, the row causes exactly
  // the single result in want, which is plain from the byte and the hold state.
  // All other rows are checked against the predictor.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    seg_result_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // Single bytes from an empty hold: both ASCII extremes, the lowest
    // continuation pattern and the top of the illegal lead range.
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, 2'd0}},
    '{8'h7F, 1'b1, 1'b1, '{8'h7F, 1'b1, 1'b1, 1'b1, 2'd0}},
    '{8'h80, 1'b0, 1'b1, '{8'h80, 1'b1, 1'b1, 1'b0, 2'd0}},
    '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0, 2'd0}},
    '{8'hF8, 1'b0, 1'b1, '{8'hF8, 1'b1, 1'b1, 1'b0, 2'd0}},
    // Complete sequences of two, three and four bytes.
    '{8'hC3, 1'b0, 1'b0, '0},
    '{8'hA9, 1'b0, 1'b0, '0},
    '{8'hE2, 1'b0, 1'b0, '0},
    '{8'h82, 1'b0, 1'b0, '0},
    '{8'hAC, 1'b0, 1'b0, '0},
    '{8'hF0, 1'b0, 1'b0, '0},
    '{8'h9F, 1'b0, 1'b0, '0},
    '{8'h98, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    // Missing continuation: held bytes go out as they are and the
    // offending byte starts over, once as ASCII and once as a new lead.
    '{8'hE4, 1'b0, 1'b0, '0},
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'hF4, 1'b0, 1'b0, '0},
    '{8'h8F, 1'b0, 1'b0, '0},
    '{8'hC2, 1'b0, 1'b0, '0},
    // Chunk end that leaves nothing held after a flush.
    '{8'h7F, 1'b1, 1'b0, '0},
    // Chunk end with one, two and three bytes held: a bare end marker.
    '{8'hC2, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 2'd1}},
    '{8'hE2, 1'b0, 1'b0, '0},
    '{8'h82, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 2'd2}},
    '{8'hF0, 1'b0, 1'b0, '0},
    '{8'h90, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 2'd3}}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  utf8_sequence_segmenter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] in_byte
    .in_tlast   (in_tlast),    // chunk_end
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] out_byte, [9:8] dropped_count, [15:10] zero
    .out_tlast  (out_tlast),   // run_last
    .out_tuser  (out_tuser)    // [0] byte_present, [1] chunk_done
  );

  always #5 clk = ~clk;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int cycle_count    = 0;
  int error_count    = 0;
  int bytes_sent     = 0;
  int chunks_sent    = 0;
  int results_seen   = 0;
  int markers_seen   = 0;

  // Predictor state: the bytes of the open sequence and its length.
  logic [7:0] hold_buf [3];
  logic [1:0] hold_cnt = 2'd0;
  logic [2:0] seq_len  = utf8seg_pkg::LEN_SINGLE;

  // Results of the request being predicted, and all results still owed.
  seg_result_t step_results     [$];
  seg_result_t expected_results [$];

  // Sequence length announced by a lead byte; ASCII and illegal leads
  // both come back as LEN_SINGLE and go out alone.
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    if (b < utf8seg_pkg::ASCII_LIMIT) return utf8seg_pkg::LEN_SINGLE;
    if ((b & utf8seg_pkg::MASK_2) == utf8seg_pkg::LEAD_2) return utf8seg_pkg::LEN_TWO;
    if ((b & utf8seg_pkg::MASK_3) == utf8seg_pkg::LEAD_3) return utf8seg_pkg::LEN_THREE;
    if ((b & utf8seg_pkg::MASK_4) == utf8seg_pkg::LEAD_4) return utf8seg_pkg::LEN_FOUR;
    return utf8seg_pkg::LEN_SINGLE;
  endfunction

  function automatic seg_result_t byte_result(input logic [7:0] b);
    seg_result_t r;
    r         = '0;
    r.data    = b;
    r.present = 1'b1;
    return r;
  endfunction

  // Appends one predicted result to those of the current request.
  task automatic add_step_result(input seg_result_t r);
    step_results = {step_results, r};
  endtask

  // A byte seen with nothing held either passes at once or opens a sequence.
  task automatic open_or_pass(input logic [7:0] b);
    logic [2:0] len;
    len = lead_length(b);
    if (len == utf8seg_pkg::LEN_SINGLE) begin
      add_step_result(byte_result(b));
    end else begin
      hold_buf[0] = b;
      hold_cnt    = 2'd1;
      seq_len     = len;
    end
  endtask

  task automatic release_hold();
    for (int k = 0; k < hold_cnt; k++) add_step_result(byte_result(hold_buf[k]));
    hold_cnt = 2'd0;
    seq_len  = utf8seg_pkg::LEN_SINGLE;
  endtask

  // Works out the results of one accepted input request into step_results.
  task automatic segment_byte(input logic [7:0] b, input logic last);
    seg_result_t tail;
    step_results.delete();
    if (hold_cnt == 2'd0 || seq_len == utf8seg_pkg::LEN_SINGLE) begin
      hold_cnt = 2'd0;
      seq_len  = utf8seg_pkg::LEN_SINGLE;
      open_or_pass(b);
    end else if ((b & utf8seg_pkg::MASK_CONT) == utf8seg_pkg::CONT_BITS) begin
      if ({1'b0, hold_cnt} + 3'd1 >= seq_len) begin
        // The completing continuation releases the whole sequence.
        release_hold();
        add_step_result(byte_result(b));
      end else begin
        hold_buf[hold_cnt] = b;
        hold_cnt           = hold_cnt + 2'd1;
      end
    end else begin
      // Not a continuation: flush what is held, then start over with b.
      release_hold();
      open_or_pass(b);
    end
    if (last) begin
      // An unfinished sequence is dropped and reported by a bare marker.
      if (hold_cnt != 2'd0 || step_results.size() == 0) begin
        tail         = '0;
        tail.dropped = hold_cnt;
        add_step_result(tail);
      end
      tail            = step_results[step_results.size()-1];
      tail.chunk_done = 1'b1;
      step_results[step_results.size()-1] = tail;
      hold_cnt = 2'd0;
      seq_len  = utf8seg_pkg::LEN_SINGLE;
    end
    if (step_results.size() != 0) begin
      tail          = step_results[step_results.size()-1];
      tail.run_last = 1'b1;
      step_results[step_results.size()-1] = tail;
    end
  endtask

  // Offers one input request, waits for it to be taken and records what it
  // owes. A typed row replaces the prediction but still advances the state.
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input logic typed, input seg_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    segment_byte(b, last);
    if (typed) begin
      expected_results = {expected_results, want};
    end else begin
      foreach (step_results[i]) expected_results = {expected_results, step_results[i]};
    end
    bytes_sent++;
    if (last) chunks_sent++;
  endtask

  // Random traffic: mostly well-formed sequences with random payload bits,
  // some cut short, plus illegal leads and fully random bytes. Chunk ends
  // land on any byte, so they often cut a sequence in the middle.
  task automatic send_random_traffic(input int n_items);
    int         sent;
    int         len;
    int         keep;
    int         pick;
    logic [7:0] b;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        len  = $urandom_range(4, 1);
        keep = ($urandom_range(9) == 0) ? $urandom_range(len, 1) : len;
        case (len)
          1:       b = 8'($urandom_range(127));
          2:       b = 8'hC0 | 8'($urandom_range(31));
          3:       b = 8'hE0 | 8'($urandom_range(15));
          default: b = 8'hF0 | 8'($urandom_range(7));
        endcase
        for (int k = 0; k < keep; k++) begin
          if (k != 0) b = 8'h80 | 8'($urandom_range(63));
          send_byte(b, $urandom_range(15) == 0, 1'b0, '0);
          sent++;
        end
      end else if (pick < 85) begin
        b = $urandom_range(1) ? (8'h80 | 8'($urandom_range(63))) : (8'hF8 | 8'($urandom_range(7)));
        send_byte(b, $urandom_range(15) == 0, 1'b0, '0);
        sent++;
      end else begin
        send_byte(8'($urandom_range(255)), $urandom_range(15) == 0, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every accepted result request is checked against the oldest one owed.
  seg_result_t want_r;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (!out_tuser[0]) markers_seen++;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("ERROR: unexpected result byte=%02h present=%b last=%b done=%b dropped=%0d",
                   out_tdata[7:0], out_tuser[0], out_tlast, out_tuser[1], out_tdata[9:8]);
      end else begin
        want_r = expected_results.pop_front();
        if (out_tdata[7:0] !== want_r.data || out_tuser[0] !== want_r.present ||
            out_tlast !== want_r.run_last || out_tuser[1] !== want_r.chunk_done ||
            out_tdata[9:8] !== want_r.dropped || out_tdata[15:10] !== 6'd0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $write("ERROR: result %0d expected byte=%02h present=%b last=%b done=%b dropped=%0d,",
                   results_seen, want_r.data, want_r.present, want_r.run_last,
                   want_r.chunk_done, want_r.dropped);
            $display(" got byte=%02h present=%b last=%b done=%b dropped=%0d pad=%02h",
                     out_tdata[7:0], out_tuser[0], out_tlast, out_tuser[1], out_tdata[9:8],
                     out_tdata[15:10]);
          end
        end
      end
    end
  end

  // Watchdog for a block that stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results still owed",
               cycle_count, expected_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table with both sides running flat out.
    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);

    // Random phases: no idling, a sparse sender, a stalling receiver, and
    // both sides idling now and then.
    send_random_traffic(RANDOM_ITEMS);
    send_idle_pct = 67;
    send_random_traffic(RANDOM_ITEMS);
    send_idle_pct  = 0;
    recv_stall_pct = 67;
    send_random_traffic(RANDOM_ITEMS);
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    send_random_traffic(RANDOM_ITEMS);
    in_tvalid <= 1'b0;

    // Let the owed results come out, then watch for stray ones.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      error_count++;
      $display("ERROR: %0d expected results never arrived", expected_results.size());
    end

    $display("Sent %0d bytes with %0d chunk ends under four handshake pressure phases.",
             bytes_sent, chunks_sent);
    $display("Checked %0d result requests, %0d of them bare end markers; %0d errors.",
             results_seen, markers_seen, error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
